FILE: rtl/fbaf_pkg.sv
`timescale 1ns / 1ps

package fbaf_pkg;

  localparam int DEF_TAPS           = 63;
  localparam int DEF_SAMPLE_RATE_HZ = 16000;
  localparam int DEF_COEF_FRAC_BITS = 17;

  localparam int LOW_CUT_HZ  = 50;
  localparam int HIGH_CUT_HZ = 300;

  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned Q30_PI      = 64'd3373259426;

  localparam int SAMPLE_W = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PIPE1,
    S_PIPE2,
    S_DONE
  } fbaf_state_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic load;
    logic bypass;
  } fbaf_ctl_t;

endpackage

FILE: rtl/fbaf_coef_rom.sv
`timescale 1ns / 1ps

module fbaf_coef_rom import fbaf_pkg::*; #(
  parameter int TAPS           = DEF_TAPS,
  parameter int SAMPLE_RATE_HZ = DEF_SAMPLE_RATE_HZ,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic [$clog2(TAPS)-1:0]         tap,
  output logic signed [COEF_FRAC_BITS:0]  coef
);

  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam longint unsigned SR64 = longint'(SAMPLE_RATE_HZ);
  localparam longint unsigned MID  = longint'(TAPS / 2);

  logic signed [COEF_W-1:0] coef_tab [TAPS];

  for (genvar j = 0; j < TAPS; j++) begin : g_tap
    localparam longint unsigned J = longint'(j);
    localparam longint unsigned A = (J >= MID) ? (J - MID) : (MID - J);

    // high cut sine, quarter turn reduction then taylor series in q30
    localparam longint unsigned NH  = (longint'(HIGH_CUT_HZ) * A) % SR64;
    localparam longint unsigned QH  = (64'd4 * NH) / SR64;
    localparam longint unsigned RH  = 64'd4 * NH - QH * SR64;
    localparam longint unsigned MH  = ((QH % 64'd2) == 64'd1) ? (SR64 - RH) : RH;
    localparam longint unsigned XH  = (MH * Q30_HALF_PI) / SR64;
    localparam longint unsigned X2H = (XH * XH) >> 30;
    localparam longint unsigned H1  = ((XH * X2H) >> 30) / 64'd6;
    localparam longint unsigned H2  = ((H1 * X2H) >> 30) / 64'd20;
    localparam longint unsigned H3  = ((H2 * X2H) >> 30) / 64'd42;
    localparam longint unsigned H4  = ((H3 * X2H) >> 30) / 64'd72;
    localparam longint unsigned H5  = ((H4 * X2H) >> 30) / 64'd110;
    localparam longint unsigned H6  = ((H5 * X2H) >> 30) / 64'd156;
    localparam longint unsigned H7  = ((H6 * X2H) >> 30) / 64'd210;
    localparam longint SH = longint'(XH) - longint'(H1) + longint'(H2) - longint'(H3)
                          + longint'(H4) - longint'(H5) + longint'(H6) - longint'(H7);
    localparam longint HI = (QH >= 64'd2) ? -SH : SH;

    // low cut sine
    localparam longint unsigned NL  = (longint'(LOW_CUT_HZ) * A) % SR64;
    localparam longint unsigned QL  = (64'd4 * NL) / SR64;
    localparam longint unsigned RL  = 64'd4 * NL - QL * SR64;
    localparam longint unsigned ML  = ((QL % 64'd2) == 64'd1) ? (SR64 - RL) : RL;
    localparam longint unsigned XL  = (ML * Q30_HALF_PI) / SR64;
    localparam longint unsigned X2L = (XL * XL) >> 30;
    localparam longint unsigned L1  = ((XL * X2L) >> 30) / 64'd6;
    localparam longint unsigned L2  = ((L1 * X2L) >> 30) / 64'd20;
    localparam longint unsigned L3  = ((L2 * X2L) >> 30) / 64'd42;
    localparam longint unsigned L4  = ((L3 * X2L) >> 30) / 64'd72;
    localparam longint unsigned L5  = ((L4 * X2L) >> 30) / 64'd110;
    localparam longint unsigned L6  = ((L5 * X2L) >> 30) / 64'd156;
    localparam longint unsigned L7  = ((L6 * X2L) >> 30) / 64'd210;
    localparam longint SL = longint'(XL) - longint'(L1) + longint'(L2) - longint'(L3)
                          + longint'(L4) - longint'(L5) + longint'(L6) - longint'(L7);
    localparam longint LO = (QL >= 64'd2) ? -SL : SL;

    localparam longint D = HI - LO;
    localparam longint unsigned MAG =
      longint'((D < 0) ? -D : D) << COEF_FRAC_BITS;
    localparam longint unsigned DEN = Q30_PI * ((A == 64'd0) ? 64'd1 : A);
    localparam longint unsigned V   = (MAG + DEN / 64'd2) / DEN;
    localparam longint unsigned CEN =
      ((longint'(2 * (HIGH_CUT_HZ - LOW_CUT_HZ)) << COEF_FRAC_BITS) + SR64 / 64'd2) / SR64;
    localparam longint C = (A == 64'd0) ? longint'(CEN) :
                           ((D < 0) ? -longint'(V) : longint'(V));

    assign coef_tab[j] = COEF_W'(C);
  end

  assign coef = coef_tab[tap];

endmodule

FILE: rtl/fbaf_delay_mem.sv
`timescale 1ns / 1ps

module fbaf_delay_mem import fbaf_pkg::*; #(
  parameter int TAPS = DEF_TAPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [$clog2(TAPS)-1:0]    waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(TAPS)-1:0]    raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [TAPS];
  logic [TAPS-1:0]            written;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       hit_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        hit_q <= written[raddr];
      end
    end
  end

  assign rdata = hit_q ? rdata_q : '0;

endmodule

FILE: rtl/fbaf_ctrl.sv
`timescale 1ns / 1ps

module fbaf_ctrl import fbaf_pkg::*; #(
  parameter int TAPS = DEF_TAPS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    filter_enable,
  input  logic                    out_free,
  output logic                    mem_we,
  output logic [$clog2(TAPS)-1:0] mem_waddr,
  output logic [$clog2(TAPS)-1:0] mem_raddr,
  output logic [$clog2(TAPS)-1:0] tap,
  output fbaf_ctl_t               ctl
);

  localparam int IDXW = $clog2(TAPS);
  localparam logic [IDXW-1:0] LAST = IDXW'(TAPS - 1);

  fbaf_state_t     state, state_next;
  logic [IDXW-1:0] wp;
  logic [IDXW-1:0] wp_dec;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] tap_cnt;
  logic            bypass;
  logic            accept;

  assign accept = in_valid && in_ready;
  assign wp_dec = (wp == '0) ? LAST : wp - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wp      <= '0;
      rd_addr <= '0;
      tap_cnt <= '0;
      bypass  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        bypass <= !filter_enable;
        if (filter_enable) begin
          wp      <= wp_dec;
          rd_addr <= wp_dec;
          tap_cnt <= '0;
        end
      end else if (state == S_READ) begin
        rd_addr <= (rd_addr == LAST) ? '0 : rd_addr + 1'b1;
        tap_cnt <= tap_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = filter_enable ? S_READ : S_DONE;
      S_READ:  if (tap_cnt == LAST) state_next = S_PIPE1;
      S_PIPE1: state_next = S_PIPE2;
      S_PIPE2: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    mem_we     = accept && filter_enable;
    mem_waddr  = wp_dec;
    mem_raddr  = rd_addr;
    tap        = tap_cnt;
    ctl.clear  = accept;
    ctl.rd_en  = (state == S_READ);
    ctl.load   = (state == S_DONE) && out_free;
    ctl.bypass = bypass;
  end

endmodule

FILE: rtl/fbaf_mac.sv
`timescale 1ns / 1ps

module fbaf_mac import fbaf_pkg::*; #(
  parameter int TAPS           = DEF_TAPS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fbaf_ctl_t                     ctl,
  input  logic signed [SAMPLE_W-1:0]    sample_in,
  input  logic                          block_end_in,
  input  logic signed [COEF_FRAC_BITS:0] coef,
  input  logic signed [SAMPLE_W-1:0]    rdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_W-1:0]    sample_out,
  output logic                          clipped,
  output logic                          block_end_out
);

  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = COEF_FRAC_BITS + SAMPLE_W + $clog2(TAPS) + 1;
  localparam int T_W    = ACC_W - COEF_FRAC_BITS;

  logic signed [COEF_W-1:0]   coef_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       rd_d1, rd_d2;
  logic signed [SAMPLE_W-1:0] sample_hold;
  logic                       block_end_hold;

  logic [ACC_W-1:0]           mag;
  logic [T_W-1:0]             t;
  logic                       sat;
  logic [SAMPLE_W-1:0]        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_d1 <= 1'b0;
      rd_d2 <= 1'b0;
    end else begin
      rd_d1 <= ctl.rd_en;
      rd_d2 <= rd_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sample_hold    <= sample_in;
      block_end_hold <= block_end_in;
      acc            <= '0;
    end else if (rd_d2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctl.rd_en) begin
      coef_q <= coef;
    end
    if (rd_d1) begin
      prod <= rdata * coef_q;
    end
  end

  // truncate toward zero, then saturate
  always_comb begin
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    t   = mag[ACC_W-1:COEF_FRAC_BITS];
    if (acc[ACC_W-1]) begin
      sat = t > T_W'(32768);
      res = sat ? 16'h8000 : SAMPLE_W'(-t);
    end else begin
      sat = t > T_W'(32767);
      res = sat ? 16'h7fff : t[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_out    <= ctl.bypass ? sample_hold : res;
      clipped       <= ctl.bypass ? 1'b0 : sat;
      block_end_out <= block_end_hold;
    end
  end

endmodule

FILE: rtl/fir_bandpass_audio_filter_unit.sv
`timescale 1ns / 1ps

// Band-pass FIR for 16-bit audio: each word in gives one word out, the dot product of the
// last TAPS samples (newest first) with a fixed 50 Hz to 300 Hz sinc-difference table,
// truncated toward zero and saturated, with clipped set when saturation happened.
// The delay line sits in a single-port-read memory and one multiplier walks it one tap
// per cycle. A filtered word passes the READ, PIPE1, PIPE2 and DONE states before it
// reaches the output register, and the next word is taken the cycle after that.
// With filter_enable low a word goes straight to DONE and reaches the output register
// as soon as it is free; the next word waits for that, and the delay line is kept.
// The output register lets a new word in while the last result waits to be taken; a
// result that is still waiting when the next one is ready holds the block until it goes.

module fir_bandpass_audio_filter_unit import fbaf_pkg::*; #(
  parameter int TAPS           = DEF_TAPS,
  parameter int SAMPLE_RATE_HZ = DEF_SAMPLE_RATE_HZ,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       block_end_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       clipped,
  output logic                       block_end_out
);

  localparam int IDXW = $clog2(TAPS);

  logic                          filter_enable;
  logic                          out_free;
  logic                          mem_we;
  logic [IDXW-1:0]               mem_waddr;
  logic [IDXW-1:0]               mem_raddr;
  logic [IDXW-1:0]               tap;
  logic signed [COEF_FRAC_BITS:0] coef;
  logic signed [SAMPLE_W-1:0]    rdata;
  fbaf_ctl_t                     ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      filter_enable <= cfg_wr_data;
    end
  end

  assign out_free = !out_valid || out_ready;

  fbaf_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .filter_enable (filter_enable),
    .out_free      (out_free),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_raddr     (mem_raddr),
    .tap           (tap),
    .ctl           (ctl)
  );

  fbaf_delay_mem #(
    .TAPS (TAPS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (sample_in),
    .re    (ctl.rd_en),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  fbaf_coef_rom #(
    .TAPS           (TAPS),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_rom (
    .tap  (tap),
    .coef (coef)
  );

  fbaf_mac #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sample_in     (sample_in),
    .block_end_in  (block_end_in),
    .coef          (coef),
    .rdata         (rdata),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .sample_out    (sample_out),
    .clipped       (clipped),
    .block_end_out (block_end_out)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fbaf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } audio_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
    logic                       block_end;
  } audio_out_t;

  localparam int MAX_WAIT = 14;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic                       cfg_wr_data = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       block_end_in = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;
  logic                       block_end_out;

  // band-pass table and the predictor's own copy of the block state
  longint                     band_coef[DEF_TAPS];
  logic signed [SAMPLE_W-1:0] tap_line[DEF_TAPS];
  bit                         filter_on;

  audio_in_t  words_to_send[$];
  audio_out_t expected_audio[$];

  int send_gap = 0;
  int recv_wait = 0;
  int recv_hold;
  int stretch_left[2] = '{0, 0};
  bit stretch_quiet[2];
  audio_in_t next_word;

  int mismatch_count = 0;
  int words_in = 0;
  int filtered_count = 0;
  int bypassed_count = 0;
  int saturated_count = 0;

  fir_bandpass_audio_filter_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_in    (sample_in),
    .block_end_in (block_end_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .clipped      (clipped),
    .block_end_out(block_end_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  // sin(2*pi*n/sr) in Q30, quarter-turn reduction then Taylor series to x^15
  function automatic longint sine_q30(longint unsigned n, longint unsigned sr);
    longint unsigned quad, rem, m, x, x2, term;
    longint s;
    quad = (4 * n) / sr;
    rem  = 4 * n - quad * sr;
    m    = quad[0] ? sr - rem : rem;
    x    = (m * Q30_HALF_PI) / sr;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    return (quad >= 2) ? -s : s;
  endfunction

  function automatic void build_band_coefs();
    longint unsigned lag, num, mag, den, v;
    longint hi, lo, d;
    for (int j = 0; j < DEF_TAPS; j++) begin
      lag = (j >= DEF_TAPS / 2) ? j - DEF_TAPS / 2 : DEF_TAPS / 2 - j;
      if (lag == 0) begin
        num = longint'(2 * (HIGH_CUT_HZ - LOW_CUT_HZ)) << DEF_COEF_FRAC_BITS;
        band_coef[j] = longint'((num + DEF_SAMPLE_RATE_HZ / 2) / DEF_SAMPLE_RATE_HZ);
      end else begin
        hi = sine_q30((HIGH_CUT_HZ * lag) % DEF_SAMPLE_RATE_HZ, DEF_SAMPLE_RATE_HZ);
        lo = sine_q30((LOW_CUT_HZ * lag) % DEF_SAMPLE_RATE_HZ, DEF_SAMPLE_RATE_HZ);
        d = hi - lo;
        mag = longint'((d < 0) ? -d : d) << DEF_COEF_FRAC_BITS;
        den = Q30_PI * lag;
        v = (mag + den / 2) / den;
        band_coef[j] = (d < 0) ? -longint'(v) : longint'(v);
      end
    end
  endfunction

  // newest sample at index 0, sum truncated toward zero then saturated
  function automatic audio_out_t run_filter(audio_in_t w);
    audio_out_t r;
    longint acc;
    longint unsigned mag;
    r.sample    = w.sample;
    r.clipped   = 1'b0;
    r.block_end = w.block_end;
    if (filter_on) begin
      for (int j = DEF_TAPS - 1; j > 0; j--) tap_line[j] = tap_line[j - 1];
      tap_line[0] = w.sample;
      acc = 0;
      for (int j = 0; j < DEF_TAPS; j++) acc += band_coef[j] * longint'(tap_line[j]);
      if (acc < 0) begin
        mag = longint'(-acc) >> DEF_COEF_FRAC_BITS;
        if (mag > 32768) begin
          mag = 32768;
          r.clipped = 1'b1;
        end
        r.sample = SAMPLE_W'(-longint'(mag));
      end else begin
        mag = longint'(acc) >> DEF_COEF_FRAC_BITS;
        if (mag > 32767) begin
          mag = 32767;
          r.clipped = 1'b1;
        end
        r.sample = SAMPLE_W'(mag);
      end
    end
    return r;
  endfunction

  // side 0 is the sender, side 1 the receiver; calm and busy stretches follow in random order
  function automatic int draw_wait(int side);
    if (stretch_left[side] == 0) begin
      stretch_quiet[side] = ($urandom_range(0, 2) == 0);
      stretch_left[side]  = $urandom_range(8, 40);
    end
    stretch_left[side]--;
    return stretch_quiet[side] ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_word(input int value, input bit last);
    audio_in_t w;
    w.sample    = value[SAMPLE_W-1:0];
    w.block_end = last;
    words_to_send = {words_to_send, w};
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (words_to_send.size() > 0 || in_valid || expected_audio.size() > 0);
  endtask

  task automatic set_filter(input bit en);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    filter_on = en;
    @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (words_to_send.size() > 0) begin
        next_word = words_to_send.pop_front();
        in_valid     <= 1'b1;
        sample_in    <= next_word.sample;
        block_end_in <= next_word.block_end;
        send_gap     <= draw_wait(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid && out_ready) begin
      recv_hold = draw_wait(1);
      recv_wait <= recv_hold;
      out_ready <= (recv_hold == 0);
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on each accepted word, check each result word
  always @(posedge clk) begin
    audio_in_t  got_in;
    audio_out_t want;
    if (rst) begin
      for (int j = 0; j < DEF_TAPS; j++) tap_line[j] = '0;
      filter_on = 1'b1;
      expected_audio.delete();
    end else begin
      if (in_valid && in_ready) begin
        got_in.sample    = sample_in;
        got_in.block_end = block_end_in;
        words_in++;
        if (filter_on) filtered_count++;
        else bypassed_count++;
        expected_audio = {expected_audio, run_filter(got_in)};
      end
      if (out_valid && out_ready) begin
        if (expected_audio.size() == 0) begin
          report_mismatch($sformatf("unexpected word sample_out=%0d", sample_out));
        end else begin
          want = expected_audio.pop_front();
          if (want.clipped) saturated_count++;
          if (sample_out !== want.sample)
            report_mismatch($sformatf("sample_out %0d, want %0d", sample_out, want.sample));
          if (clipped !== want.clipped)
            report_mismatch($sformatf("clipped %b, want %b", clipped, want.clipped));
          if (block_end_out !== want.block_end)
            report_mismatch($sformatf("block_end_out %b, want %b", block_end_out,
                                      want.block_end));
        end
      end
    end
  end

  initial begin : stimulus
    int kind, len, half, amp, mag, count, target;
    bit pol, en;
    build_band_coefs();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // start-up from an empty delay line, filter on from reset
    push_word(32767, 1'b0);
    push_word(-32768, 1'b1);
    push_word(0, 1'b0);
    push_word(-1, 1'b0);
    push_word(1, 1'b1);
    push_word(16'h5555, 1'b0);
    push_word(16'hAAAA, 1'b0);
    push_word(32767, 1'b0);
    push_word(32767, 1'b1);
    push_word(-32768, 1'b0);
    wait_idle();

    // bypass keeps the delay line
    set_filter(1'b0);
    push_word(-32768, 1'b1);
    push_word(32767, 1'b0);
    push_word(0, 1'b0);
    push_word(-1, 1'b1);
    push_word(16'h5A5A, 1'b0);
    wait_idle();

    set_filter(1'b1);
    push_word(1234, 1'b0);
    push_word(-1234, 1'b1);
    push_word(0, 1'b0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      en = !(p == 2 || p == 5);
      set_filter(en);
      count  = 0;
      target = 85;
      while (count < target) begin
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
          // sign pattern matched to the table, drives the sum to its limits
          pol = $urandom_range(0, 1);
          for (int j = DEF_TAPS - 1; j >= 0; j--) begin
            mag = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(26000, 32767);
            if ((band_coef[j] >= 0) ^ pol) push_word(mag, j == 0);
            else push_word(-mag - 1, j == 0);
          end
          count += DEF_TAPS;
        end else begin
          len = $urandom_range(8, 120);
          if (len > target - count) len = target - count;
          half = $urandom_range(8, 80);
          amp  = $urandom_range(8000, 32767);
          pol  = $urandom_range(0, 1);
          for (int n = 0; n < len; n++) begin
            case (kind)
              3, 4: mag = (((n / half) % 2) ^ pol) ? -amp : amp;
              5, 6: mag = $urandom_range(0, 65535);
              7: mag = $urandom_range(0, 600) - 300;
              8: mag = (n != 0) ? 0 : (pol ? -32768 : 32767);
              default: mag = $urandom_range(0, 1) ? -32768 : 32767;
            endcase
            push_word(mag, (n == len - 1) || ($urandom_range(0, 7) == 0));
          end
          count += len;
        end
      end
      wait_idle();
    end

    wait_idle();
    repeat (80) @(posedge clk);
    $display("covered %0d words: %0d filtered, %0d bypassed, %0d saturated",
             words_in, filtered_count, bypassed_count, saturated_count);
    $display("filter switched on and off across 11 phases, random stalls on both sides");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
